// ===== hw/rtl/imt_pkg.sv =====
// Shared types and constants of the interval membership table.
package imt_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 16;
   localparam int unsigned TIME_W           = 32;
   localparam int unsigned SPAN_W           = 31;
   localparam int unsigned IDX_W            = 4;
   localparam int unsigned CNT_OUT_W        = 5;

   typedef enum logic [1:0] {
      CMD_APPEND       = 2'd0,
      CMD_REMOVE_TIME  = 2'd1,
      CMD_REMOVE_INDEX = 2'd2,
      CMD_QUERY        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_NO_INDEX = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } state_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [TIME_W-1:0]  point_time;
      logic [SPAN_W-1:0]         span_length;
      logic [IDX_W-1:0]          entry_index;
   } req_type;

   typedef struct packed {
      logic                      hit;
      status_type                status;
      logic [CNT_OUT_W-1:0]      entry_count;
      logic [CNT_OUT_W-1:0]      removed_count;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic scan;
      logic load;
   } ctl_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage

// ===== hw/rtl/imt_ctrl.sv =====
// Controller state machine of the interval membership table.
module imt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output imt_pkg::ctl_type  ctl,
   input  imt_pkg::sts_type  sts
);

   imt_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imt_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctl       = '0;
      case (state_ff)
         imt_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.start = 1'b1;
               state_in  = imt_pkg::FSM_SCAN;
            end
         end
         imt_pkg::FSM_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = imt_pkg::FSM_FINISH;
            end
         end
         imt_pkg::FSM_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load = 1'b1;
               state_in = imt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = imt_pkg::FSM_IDLE;
         end
      endcase

      if (ctl.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == imt_pkg::FSM_FINISH)
      else $error("result raised outside finish");

   a_no_scan_after_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == imt_pkg::FSM_SCAN)
      else $error("accepted transaction did not start a scan");

endmodule

// ===== hw/rtl/imt_dpath.sv =====
// Datapath of the interval membership table: entry store, scan pointers, result.
module imt_dpath #(
   parameter int unsigned CAPACITY = imt_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  imt_pkg::ctl_type  ctl,
   output imt_pkg::sts_type  sts,
   input  imt_pkg::req_type  req_data,
   output imt_pkg::rsp_type  rsp_data
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned XW = (CW > imt_pkg::IDX_W) ? CW : imt_pkg::IDX_W;

   // entry store
   logic signed [imt_pkg::TIME_W-1:0] start_mem [CAPACITY];
   logic [imt_pkg::SPAN_W-1:0]        len_mem   [CAPACITY];

   logic                              wr_en;
   logic [IW-1:0]                     wr_addr;
   logic signed [imt_pkg::TIME_W-1:0] wr_start;
   logic [imt_pkg::SPAN_W-1:0]        wr_len;

   // control state
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] r_ff, r_in;
   logic [CW-1:0] w_ff, w_in;
   logic [CW-1:0] end_ff, end_in;
   logic [CW-1:0] removed_ff, removed_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          compact_ff, compact_in;
   logic          hit_ff, hit_in;

   // transaction fields
   imt_pkg::cmd_type                  cmd_ff, cmd_in;
   logic signed [imt_pkg::TIME_W-1:0] t_ff, t_in;
   logic [imt_pkg::IDX_W-1:0]         idx_ff, idx_in;
   imt_pkg::status_type               status_ff, status_in;

   // read stage
   logic signed [imt_pkg::TIME_W-1:0] rd_start_ff;
   logic [imt_pkg::SPAN_W-1:0]        rd_len_ff;
   logic [IW-1:0]                     rd_k_ff;

   imt_pkg::rsp_type rsp_ff, rsp_in;

   logic                issue;
   logic                covers;
   logic                drop;
   logic signed [32:0]  s_x, e_x, t_x;
   logic [CW-1:0]       final_count;

   always_comb begin
      s_x    = 33'(rd_start_ff);
      e_x    = s_x + $signed({2'b00, rd_len_ff});
      t_x    = 33'(t_ff);
      covers = (t_x >= s_x) && (t_x <= e_x);
   end

   always_comb begin
      count_in    = count_ff;
      r_in        = r_ff;
      w_in        = w_ff;
      end_in      = end_ff;
      removed_in  = removed_ff;
      rd_valid_in = 1'b0;
      compact_in  = compact_ff;
      hit_in      = hit_ff;
      cmd_in      = cmd_ff;
      t_in        = t_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      wr_addr     = w_ff[IW-1:0];
      wr_start    = rd_start_ff;
      wr_len      = rd_len_ff;
      issue       = 1'b0;
      drop        = 1'b0;
      final_count = compact_ff ? w_ff : count_ff;

      if (ctl.start) begin
         cmd_in     = req_data.cmd;
         t_in       = req_data.point_time;
         idx_in     = req_data.entry_index;
         status_in  = imt_pkg::STS_OK;
         hit_in     = 1'b0;
         removed_in = '0;
         r_in       = '0;
         w_in       = '0;
         end_in     = '0;
         compact_in = 1'b0;
         case (req_data.cmd)
            imt_pkg::CMD_APPEND: begin
               if (count_ff == CW'(CAPACITY)) begin
                  status_in = imt_pkg::STS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IW-1:0];
                  wr_start = req_data.point_time;
                  wr_len   = req_data.span_length;
                  count_in = count_ff + CW'(1);
               end
            end
            imt_pkg::CMD_REMOVE_INDEX: begin
               if (XW'(req_data.entry_index) < XW'(count_ff)) begin
                  // entries below the index stay put: start the pass there
                  r_in       = CW'(req_data.entry_index);
                  w_in       = CW'(req_data.entry_index);
                  end_in     = count_ff;
                  compact_in = 1'b1;
               end else begin
                  status_in = imt_pkg::STS_NO_INDEX;
               end
            end
            imt_pkg::CMD_REMOVE_TIME: begin
               end_in     = count_ff;
               compact_in = 1'b1;
            end
            default: begin
               end_in = count_ff;
            end
         endcase
      end

      if (ctl.scan) begin
         issue = (r_ff != end_ff);
         if (issue) begin
            r_in = r_ff + CW'(1);
         end
         rd_valid_in = issue;
         if (rd_valid_ff) begin
            case (cmd_ff)
               imt_pkg::CMD_REMOVE_TIME:  drop = covers;
               imt_pkg::CMD_REMOVE_INDEX: drop = (XW'(rd_k_ff) == XW'(idx_ff));
               default:                   drop = 1'b0;
            endcase
            if (cmd_ff == imt_pkg::CMD_QUERY && covers) begin
               hit_in = 1'b1;
            end
            if (compact_ff) begin
               if (drop) begin
                  removed_in = removed_ff + CW'(1);
               end else begin
                  // close the gap: move the kept entry down to the write pointer
                  wr_en = 1'b1;
                  w_in  = w_ff + CW'(1);
               end
            end
         end
      end

      if (ctl.load) begin
         count_in             = final_count;
         rsp_in.hit           = hit_ff;
         rsp_in.status        = status_ff;
         rsp_in.entry_count   = imt_pkg::CNT_OUT_W'(final_count);
         rsp_in.removed_count = imt_pkg::CNT_OUT_W'(removed_ff);
      end
   end

   assign sts.scan_done = (r_ff == end_ff) && !rd_valid_ff;
   assign rsp_data      = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         r_ff        <= '0;
         w_ff        <= '0;
         end_ff      <= '0;
         removed_ff  <= '0;
         rd_valid_ff <= 1'b0;
         compact_ff  <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         count_ff    <= count_in;
         r_ff        <= r_in;
         w_ff        <= w_in;
         end_ff      <= end_in;
         removed_ff  <= removed_in;
         rd_valid_ff <= rd_valid_in;
         compact_ff  <= compact_in;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      t_ff      <= t_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr] <= wr_start;
         len_mem[wr_addr]   <= wr_len;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_start_ff <= start_mem[r_ff[IW-1:0]];
         rd_len_ff   <= len_mem[r_ff[IW-1:0]];
         rd_k_ff     <= r_ff[IW-1:0];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_write_behind_read: assert property (@(posedge clock) disable iff (reset)
      w_ff <= r_ff)
      else $error("write pointer overtook read pointer");

   a_scan_write_below: assert property (@(posedge clock) disable iff (reset)
      (ctl.scan && wr_en) |-> (w_ff < r_ff))
      else $error("compaction write at or above read address");

   a_pass_within_count: assert property (@(posedge clock) disable iff (reset)
      ctl.scan |-> (end_ff <= count_ff))
      else $error("scan limit beyond stored entries");

endmodule

// ===== hw/rtl/interval_membership_table.sv =====
// Top level of the interval membership table: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  req     | in        | req_valid / req_ready | req_data (cmd, time, span, idx)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_data (hit, status, counts)
//
// Remove-by-time and query read one stored interval per cycle; each read is registered
// and compared after it, and the scan ends with the last compare.
// Remove-at-index reads only from the index up; append and rejected commands read none.
// Reset clears the entry count and the controller; the store needs no clearing.
// A stalled result holds the output register; the next transaction is accepted
// meanwhile and waits at its finish step until that register is free.
module interval_membership_table #(
   parameter int unsigned CAPACITY = imt_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  imt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output imt_pkg::rsp_type  rsp_data
);

   // command and status between the two halves
   imt_pkg::ctl_type ctl;
   imt_pkg::sts_type sts;

   // Sequence the transaction: accept, scan, then load the result.
   imt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   // Hold the intervals, compare and compact one entry per cycle.
   imt_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sts      (sts),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/sv/imt_checker.sv =====
// Checker for the interval membership table: predicts every transaction's result and compares.
`timescale 1ns / 1ps

module imt_checker #(
   parameter int unsigned CAPACITY = imt_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  imt_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  imt_pkg::rsp_type  rsp_data,
   output int unsigned       fail_count,
   output int unsigned       outstanding
);

   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned TIME_W      = imt_pkg::TIME_W;
   localparam int unsigned SPAN_W      = imt_pkg::SPAN_W;
   localparam int unsigned CNT_OUT_W   = imt_pkg::CNT_OUT_W;

   // Shadow of the interval table
   logic signed [TIME_W-1:0] iv_start [CAPACITY];
   logic [SPAN_W-1:0]        iv_len   [CAPACITY];
   int unsigned              iv_count;

   imt_pkg::rsp_type awaited_rsp [$];
   int unsigned      fails;
   int unsigned      reported;

   // Closed range test, with the end formed wide enough never to overflow.
   function automatic logic interval_holds(input int unsigned k,
                                           input logic signed [TIME_W-1:0] t);
      logic signed [TIME_W+1:0] lo;
      logic signed [TIME_W+1:0] hi;
      logic signed [TIME_W+1:0] tt;
      lo = iv_start[k];
      hi = lo + $signed({3'b000, iv_len[k]});
      tt = t;
      return (tt >= lo) && (tt <= hi);
   endfunction

   // Apply one command to the shadow table and return the result it yields.
   function automatic imt_pkg::rsp_type run_table_command(input imt_pkg::req_type rq);
      imt_pkg::rsp_type r;
      int unsigned      w;
      int unsigned      removed;
      r.hit    = 1'b0;
      r.status = imt_pkg::STS_OK;
      removed  = 0;
      case (rq.cmd)
         imt_pkg::CMD_APPEND: begin
            if (iv_count >= CAPACITY) begin
               r.status = imt_pkg::STS_FULL;
            end else begin
               iv_start[iv_count] = rq.point_time;
               iv_len[iv_count]   = rq.span_length;
               iv_count++;
            end
         end
         imt_pkg::CMD_REMOVE_TIME: begin
            w = 0;
            for (int unsigned k = 0; k < iv_count; k++) begin
               if (interval_holds(k, rq.point_time)) begin
                  removed++;
               end else begin
                  iv_start[w] = iv_start[k];
                  iv_len[w]   = iv_len[k];
                  w++;
               end
            end
            iv_count = w;
         end
         imt_pkg::CMD_REMOVE_INDEX: begin
            if (rq.entry_index < iv_count) begin
               for (int unsigned k = rq.entry_index; k + 1 < iv_count; k++) begin
                  iv_start[k] = iv_start[k + 1];
                  iv_len[k]   = iv_len[k + 1];
               end
               iv_count--;
               removed = 1;
            end else begin
               r.status = imt_pkg::STS_NO_INDEX;
            end
         end
         default: begin
            for (int unsigned k = 0; k < iv_count; k++) begin
               r.hit = r.hit | interval_holds(k, rq.point_time);
            end
         end
      endcase
      r.entry_count   = CNT_OUT_W'(iv_count);
      r.removed_count = CNT_OUT_W'(removed);
      return r;
   endfunction

   always @(posedge clock) begin
      imt_pkg::rsp_type want;
      if (reset) begin
         iv_count = 0;
         awaited_rsp.delete();
         fails    = 0;
         reported = 0;
      end else begin
         // Check the outgoing result before taking in a new command.
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               fails++;
               if (reported < MAX_REPORTS) begin
                  reported++;
                  $display({"imt_checker: unexpected result",
                            " hit=%0d status=%0d count=%0d removed=%0d"},
                           rsp_data.hit, rsp_data.status, rsp_data.entry_count,
                           rsp_data.removed_count);
               end
            end else begin
               want = awaited_rsp.pop_front();
               if (want.hit !== rsp_data.hit || want.status !== rsp_data.status ||
                   want.entry_count !== rsp_data.entry_count ||
                   want.removed_count !== rsp_data.removed_count) begin
                  fails++;
                  if (reported < MAX_REPORTS) begin
                     reported++;
                     $display({"imt_checker: mismatch expected",
                               " hit=%0d status=%0d count=%0d removed=%0d"},
                              want.hit, want.status, want.entry_count,
                              want.removed_count);
                     $display({"imt_checker:          actual  ",
                               " hit=%0d status=%0d count=%0d removed=%0d"},
                              rsp_data.hit, rsp_data.status, rsp_data.entry_count,
                              rsp_data.removed_count);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited_rsp.push_back(run_table_command(req_data));
         end
      end
      fail_count  <= fails;
      outstanding <= awaited_rsp.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top of the interval membership table: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned RANDOM_ITEMS = 650;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned TIME_W       = imt_pkg::TIME_W;
   localparam int unsigned SPAN_W       = imt_pkg::SPAN_W;
   localparam int unsigned IDX_W        = imt_pkg::IDX_W;

   // Command mixes of the random phases
   localparam int unsigned MIX_FILL  = 0;
   localparam int unsigned MIX_DRAIN = 1;
   localparam int unsigned MIX_EVEN  = 2;

   // Receiver stall modes
   localparam int unsigned STALL_NONE  = 0;
   localparam int unsigned STALL_COIN  = 1;
   localparam int unsigned STALL_BURST = 2;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   imt_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   imt_pkg::rsp_type rsp_data;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned cycle_count = 0;

   // Sender pacing
   int unsigned burst_left = 0;
   bit          bursty     = 1'b1;

   // Receiver pacing
   int unsigned stall_mode = STALL_NONE;
   int unsigned mode_left  = 0;
   int unsigned hold_left  = 0;

   // Intervals appended lately, used to aim probe times at their bounds
   logic signed [TIME_W-1:0] recent_start [16];
   logic [SPAN_W-1:0]        recent_len   [16];
   int unsigned              recent_n  = 0;
   int unsigned              recent_wr = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   interval_membership_table #(
      .CAPACITY(imt_pkg::CAPACITY_DEFAULT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   imt_checker #(
      .CAPACITY(imt_pkg::CAPACITY_DEFAULT)
   ) table_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Guard against a hung handshake: end the run as a failure past the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: switch between always ready, coin-toss ready and long stall bursts,
   // each held for a random stretch of cycles.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_BURST);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE: rsp_ready <= 1'b1;
         STALL_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default: begin
            if (hold_left != 0) begin
               hold_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 24);
            end
         end
      endcase
   end

   // Present one transaction from a falling edge and hold it until it is taken.
   // Valid is only lowered when a gap opens, so back-to-back transactions keep it high.
   task automatic send_req(input imt_pkg::req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = bursty ? $urandom_range(0, 20) : 0;
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic imt_pkg::req_type make_cmd(input imt_pkg::cmd_type c,
                                                 input logic signed [TIME_W-1:0] t,
                                                 input logic [SPAN_W-1:0] s,
                                                 input logic [IDX_W-1:0] i);
      imt_pkg::req_type rq;
      rq.cmd         = c;
      rq.point_time  = t;
      rq.span_length = s;
      rq.entry_index = i;
      return rq;
   endfunction

   // Times mostly in a narrow window around zero so intervals overlap,
   // with full-range values and the extremes mixed in.
   function automatic logic signed [TIME_W-1:0] pick_time();
      int          v;
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0, 1: v = raw;
         2: begin
            case (raw[1:0])
               2'd0:    v = 32'sh8000_0000;
               2'd1:    v = 32'sh7fff_ffff;
               2'd2:    v = 0;
               default: v = -1;
            endcase
         end
         default: v = int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      endcase
      return v;
   endfunction

   function automatic logic [SPAN_W-1:0] pick_span();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 31'h7fff_ffff;
         2:       return raw[SPAN_W-1:0];
         default: return SPAN_W'($urandom_range(0, 32'h0004_0000));
      endcase
   endfunction

   // Probe on and just beside the bounds of a recent interval, or anywhere.
   function automatic logic signed [TIME_W-1:0] pick_probe();
      logic signed [63:0] lo;
      logic signed [63:0] hi;
      logic signed [63:0] v;
      int unsigned        j;
      if (recent_n == 0 || $urandom_range(0, 1) == 0) return pick_time();
      j  = $urandom_range(0, recent_n - 1);
      lo = recent_start[j];
      hi = lo + $signed({33'b0, recent_len[j]});
      case ($urandom_range(0, 4))
         0:       v = lo - 1;
         1:       v = lo;
         2:       v = (lo + hi) >>> 1;
         3:       v = hi;
         default: v = hi + 1;
      endcase
      return v[TIME_W-1:0];
   endfunction

   function automatic imt_pkg::req_type make_random_req(input int unsigned mix);
      imt_pkg::req_type rq;
      logic [31:0]      raw;
      int unsigned      roll;
      int unsigned      w_app;
      int unsigned      w_qry;
      int unsigned      w_rmt;
      // Fill the unused fields with noise too
      raw            = $urandom;
      rq.point_time  = $urandom;
      rq.span_length = raw[SPAN_W-1:0];
      rq.entry_index = IDX_W'($urandom_range(0, 15));
      case (mix)
         MIX_FILL:  begin w_app = 60; w_qry = 20; w_rmt = 10; end
         MIX_DRAIN: begin w_app = 20; w_qry = 20; w_rmt = 30; end
         default:   begin w_app = 35; w_qry = 30; w_rmt = 15; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < w_app) begin
         rq.cmd         = imt_pkg::CMD_APPEND;
         rq.point_time  = pick_time();
         rq.span_length = pick_span();
      end else if (roll < w_app + w_qry) begin
         rq.cmd        = imt_pkg::CMD_QUERY;
         rq.point_time = pick_probe();
      end else if (roll < w_app + w_qry + w_rmt) begin
         rq.cmd        = imt_pkg::CMD_REMOVE_TIME;
         rq.point_time = pick_probe();
      end else begin
         rq.cmd = imt_pkg::CMD_REMOVE_INDEX;
      end
      return rq;
   endfunction

   initial begin
      int unsigned      k;
      int unsigned      mix;
      int unsigned      phase_left;
      imt_pkg::req_type item;

      mix        = MIX_FILL;
      phase_left = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Empty table: miss, no match and no such index
      send_req(make_cmd(imt_pkg::CMD_QUERY,        0, 31'h0000_0000, 4'd0));
      send_req(make_cmd(imt_pkg::CMD_REMOVE_TIME,  0, 31'h7fff_ffff, 4'd15));
      send_req(make_cmd(imt_pkg::CMD_REMOVE_INDEX, 0, 31'h0000_0000, 4'd0));

      // Extreme starts and spans, the end of the second one beyond 32 bits
      send_req(make_cmd(imt_pkg::CMD_APPEND, 32'sh8000_0000,  31'h0000_0000, 4'd0));
      send_req(make_cmd(imt_pkg::CMD_APPEND, 32'sh7fff_ffff,  31'h7fff_ffff, 4'd0));
      send_req(make_cmd(imt_pkg::CMD_APPEND, 32'sh0001_0000,  31'h0002_0000, 4'd0));
      send_req(make_cmd(imt_pkg::CMD_APPEND, -32'sh0001_0000, 31'h7fff_ffff, 4'd0));

      // Zero-length interval at the lowest time, start bound, top time
      send_req(make_cmd(imt_pkg::CMD_QUERY, 32'sh8000_0000, 31'h0000_0000, 4'd0));
      send_req(make_cmd(imt_pkg::CMD_QUERY, 32'sh0001_0000, 31'h0000_0000, 4'd0));
      send_req(make_cmd(imt_pkg::CMD_QUERY, 32'sh7fff_ffff, 31'h0000_0000, 4'd0));

      // Index out of range, then drop the last entry
      send_req(make_cmd(imt_pkg::CMD_REMOVE_INDEX, 0, 31'h0000_0000, 4'd15));
      send_req(make_cmd(imt_pkg::CMD_REMOVE_INDEX, 0, 31'h0000_0000, 4'd3));

      // Just past the end and just before the start miss; the end bound removes
      send_req(make_cmd(imt_pkg::CMD_QUERY,       32'sh0003_0001, 31'h0000_0000, 4'd0));
      send_req(make_cmd(imt_pkg::CMD_QUERY,       32'sh0000_ffff, 31'h0000_0000, 4'd0));
      send_req(make_cmd(imt_pkg::CMD_REMOVE_TIME, 32'sh0003_0000, 31'h0000_0000, 4'd0));

      // Fill with intervals that all cover zero, overflow, drop the last by index, then clear most at once
      for (k = 0; k < 14; k++) begin
         send_req(make_cmd(imt_pkg::CMD_APPEND, -int'(k + 1) * 65536,
                           SPAN_W'((k + 1) * 131072), IDX_W'(k)));
      end
      send_req(make_cmd(imt_pkg::CMD_APPEND,       32'sh0000_0000, 31'h0000_0001, 4'd0));
      send_req(make_cmd(imt_pkg::CMD_REMOVE_INDEX, 0, 31'h0000_0000, 4'd15));
      send_req(make_cmd(imt_pkg::CMD_REMOVE_TIME,  0, 31'h0000_0000, 4'd0));

      // Random phases, each with its own command mix and sender pacing
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (phase_left == 0) begin
            mix        = $urandom_range(MIX_FILL, MIX_EVEN);
            phase_left = $urandom_range(30, 80);
            bursty     = ($urandom_range(0, 3) != 0);
         end
         phase_left--;
         item = make_random_req(mix);
         if (item.cmd == imt_pkg::CMD_APPEND) begin
            recent_start[recent_wr] = item.point_time;
            recent_len[recent_wr]   = item.span_length;
            recent_wr               = (recent_wr + 1) % 16;
            if (recent_n < 16) recent_n++;
         end
         send_req(item);
      end

      // Drop valid, wait out the remaining results, then let the block settle
      req_valid = 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
